FILE: hw/rtl/sample_delta_coalescing_buffer_macros.svh
// Assertion macros shared by the sample delta coalescing buffer RTL.
`ifndef SAMPLE_DELTA_COALESCING_BUFFER_MACROS_SVH
`define SAMPLE_DELTA_COALESCING_BUFFER_MACROS_SVH

`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define SDCB_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sdcb assertion failed");
// An implication checked in the same cycle.
`define SDCB_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdcb assertion failed");
`else
`define SDCB_ASSERT(label, cond)
`define SDCB_ASSERT_IMPLY(label, ante, cons)
`endif

`endif

FILE: hw/rtl/sdcb_pkg.sv
// Package with types and constants of the sample delta coalescing buffer.
`timescale 1ns / 1ps

package sdcb_pkg;

  // Default sizing of the buffer.
  localparam int DEF_BUFFER_ENTRIES = 32;
  localparam int DEF_GROUP_FACTOR   = 8;
  localparam int DEF_INDEX_BITS     = 24;

  // Fixed field widths.
  localparam int WIDTH_W       = 13;
  localparam int COORD_W       = 12;
  localparam int VALUE_W       = 32;
  localparam int DELTA_INDEX_W = 24;
  localparam int PROD_W        = 26;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd1024;

  // Operation codes of an input item.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_BEGIN = 2'd0;
  localparam logic [1:0] KIND_DELTA = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INDEX,
    ST_SEARCH,
    ST_HIT_MOVE,
    ST_APPEND,
    ST_FL_BEGIN,
    ST_FL_ISSUE,
    ST_FL_EMIT,
    ST_FL_END,
    ST_FL_REBEGIN,
    ST_FIN_END,
    ST_FIN_DONE
  } state_t;

endpackage

FILE: hw/rtl/sdcb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sdcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/sample_delta_coalescing_buffer.sv
// Sample delta coalescing buffer: top level with the entry RAM and its sequencer.
// A record is accepted in ST_IDLE and indexed in ST_INDEX, then the entries are searched
// newest first via the entry RAM read port; a hit is updated or removed, a miss is appended.
// A flush emits one result per cycle while out_stall is low, set by the one RAM read port.
// Items are taken one at a time; a finished result waits in the output register.
// Synchronous reset empties the buffer, closes the group and sets the row width to 1024.
`timescale 1ns / 1ps
`include "sample_delta_coalescing_buffer_macros.svh"

module sample_delta_coalescing_buffer
  import sdcb_pkg::*;
#(
  parameter int BUFFER_ENTRIES = DEF_BUFFER_ENTRIES,
  parameter int GROUP_FACTOR   = DEF_GROUP_FACTOR,
  parameter int INDEX_BITS     = DEF_INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write.
  input  logic                     cfg_write_en,
  input  logic [WIDTH_W-1:0]       cfg_write_data,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     operation,
  input  logic [COORD_W-1:0]       pixel_col,
  input  logic [COORD_W-1:0]       pixel_row,
  input  logic [VALUE_W-1:0]       old_value,
  input  logic [VALUE_W-1:0]       new_value,
  // Output channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               kind,
  output logic [DELTA_INDEX_W-1:0] delta_index,
  output logic [VALUE_W-1:0]       delta_old,
  output logic [VALUE_W-1:0]       delta_new,
  output logic                     last
);

  localparam int PTR_W       = (BUFFER_ENTRIES > 1) ? $clog2(BUFFER_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(BUFFER_ENTRIES + 1);
  localparam int GROUP_LIMIT = BUFFER_ENTRIES * GROUP_FACTOR;
  localparam int GROUP_W     = $clog2(GROUP_LIMIT + BUFFER_ENTRIES);
  localparam int ENTRY_W     = INDEX_BITS + 2 * VALUE_W;

  // Control registers.
  state_t             state, state_next;
  logic [COUNT_W-1:0] pending_count, pending_count_next;
  logic [GROUP_W-1:0] group_count, group_count_next;
  logic               group_is_open, group_is_open_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]   cmp_ptr, cmp_ptr_next;
  logic               cmp_valid, cmp_valid_next;
  logic               srch_issue, srch_issue_next;
  logic [COUNT_W-1:0] fl_ptr, fl_ptr_next;
  logic [PTR_W-1:0]   hit_ptr, hit_ptr_next;
  logic [WIDTH_W-1:0] row_width;

  // Latched item.
  logic                  op_q;
  logic [COORD_W-1:0]    x_q, y_q;
  logic [VALUE_W-1:0]    old_q, new_q;
  logic [INDEX_BITS-1:0] idx_q;

  // RAM port signals.
  logic               ram_we, ram_re;
  logic [PTR_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Fields of the entry just read.
  logic [INDEX_BITS-1:0] rd_idx;
  logic [VALUE_W-1:0]    rd_old, rd_new;

  // Result about to be loaded into the output register.
  logic       emit, emit_delta, emit_last;
  logic [1:0] emit_kind;

  logic               in_accept, out_free;
  logic [COUNT_W-1:0] pc_minus1, fl_ptr_plus1;
  logic               fl_last;
  logic [GROUP_W-1:0] group_sum;
  logic               group_roll;
  state_t             after_flush;
  logic [PROD_W-1:0]  index_full;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign rd_idx = ram_rdata[ENTRY_W-1 -: INDEX_BITS];
  assign rd_old = ram_rdata[2*VALUE_W-1 -: VALUE_W];
  assign rd_new = ram_rdata[VALUE_W-1:0];

  assign pc_minus1    = pending_count - COUNT_W'(1);
  assign fl_ptr_plus1 = fl_ptr + COUNT_W'(1);
  assign fl_last      = (fl_ptr_plus1 == pending_count);
  assign group_sum    = group_count + GROUP_W'(pending_count);
  assign group_roll   = (group_sum >= GROUP_W'(GROUP_LIMIT));
  assign after_flush  = (op_q == OP_FINISH) ? ST_FIN_END : ST_APPEND;

  // Linear index; the product stays below 2^26.
  assign index_full = PROD_W'(y_q) * PROD_W'(row_width) + PROD_W'(x_q);

  // Entry storage: index, old value and new value in one word.
  sdcb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUFFER_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pending_count <= '0;
      group_count   <= '0;
      group_is_open <= 1'b0;
      cmp_valid     <= 1'b0;
      srch_issue    <= 1'b0;
      row_width     <= ROW_WIDTH_RESET;
    end else begin
      state         <= state_next;
      pending_count <= pending_count_next;
      group_count   <= group_count_next;
      group_is_open <= group_is_open_next;
      cmp_valid     <= cmp_valid_next;
      srch_issue    <= srch_issue_next;
      if (cfg_write_en) begin
        row_width <= cfg_write_data;
      end
    end
  end

  // Pointers and the latched item.
  always_ff @(posedge clk) begin
    rd_ptr  <= rd_ptr_next;
    cmp_ptr <= cmp_ptr_next;
    fl_ptr  <= fl_ptr_next;
    hit_ptr <= hit_ptr_next;
    if (in_accept) begin
      op_q  <= operation;
      x_q   <= pixel_col;
      y_q   <= pixel_row;
      old_q <= old_value;
      new_q <= new_value;
    end
    if (state == ST_INDEX) begin
      idx_q <= INDEX_BITS'(index_full);
    end
  end

  // Sequencer: search, update, flush and result generation.
  always_comb begin
    state_next         = state;
    pending_count_next = pending_count;
    group_count_next   = group_count;
    group_is_open_next = group_is_open;
    rd_ptr_next        = rd_ptr;
    cmp_ptr_next       = cmp_ptr;
    cmp_valid_next     = cmp_valid;
    srch_issue_next    = srch_issue;
    fl_ptr_next        = fl_ptr;
    hit_ptr_next       = hit_ptr;
    ram_we             = 1'b0;
    ram_waddr          = pending_count[PTR_W-1:0];
    ram_wdata          = {idx_q, old_q, new_q};
    ram_re             = 1'b0;
    ram_raddr          = rd_ptr;
    emit               = 1'b0;
    emit_kind          = KIND_BEGIN;
    emit_delta         = 1'b0;
    emit_last          = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_FINISH) begin
            state_next = (pending_count != '0) ? ST_FL_BEGIN : ST_FIN_END;
          end else if (old_value != new_value) begin
            state_next = ST_INDEX;
          end
        end
      end

      ST_INDEX: begin
        fl_ptr_next = '0;
        if (pending_count == '0) begin
          state_next = ST_APPEND;
        end else begin
          rd_ptr_next     = pc_minus1[PTR_W-1:0];
          srch_issue_next = 1'b1;
          cmp_valid_next  = 1'b0;
          state_next      = ST_SEARCH;
        end
      end

      // One read issued and one entry compared per cycle, newest first.
      ST_SEARCH: begin
        if (cmp_valid && rd_idx == idx_q) begin
          if (new_q == rd_old) begin
            pending_count_next = pc_minus1;
            if (COUNT_W'(cmp_ptr) != pc_minus1) begin
              ram_re       = 1'b1;
              ram_raddr    = pc_minus1[PTR_W-1:0];
              hit_ptr_next = cmp_ptr;
              state_next   = ST_HIT_MOVE;
            end else begin
              state_next = ST_IDLE;
            end
          end else begin
            ram_we     = 1'b1;
            ram_waddr  = cmp_ptr;
            ram_wdata  = {rd_idx, rd_old, new_q};
            state_next = ST_IDLE;
          end
        end else if (cmp_valid && cmp_ptr == '0) begin
          if (pending_count >= COUNT_W'(BUFFER_ENTRIES)) begin
            state_next = ST_FL_BEGIN;
          end else begin
            state_next = ST_APPEND;
          end
        end else if (srch_issue) begin
          ram_re         = 1'b1;
          ram_raddr      = rd_ptr;
          cmp_ptr_next   = rd_ptr;
          cmp_valid_next = 1'b1;
          if (rd_ptr == '0) begin
            srch_issue_next = 1'b0;
          end else begin
            rd_ptr_next = rd_ptr - PTR_W'(1);
          end
        end else begin
          cmp_valid_next = 1'b0;
        end
      end

      // The last entry fills the slot of the removed one.
      ST_HIT_MOVE: begin
        ram_we     = 1'b1;
        ram_waddr  = hit_ptr;
        ram_wdata  = ram_rdata;
        state_next = ST_IDLE;
      end

      ST_APPEND: begin
        ram_we             = 1'b1;
        ram_waddr          = pending_count[PTR_W-1:0];
        ram_wdata          = {idx_q, old_q, new_q};
        pending_count_next = pending_count + COUNT_W'(1);
        state_next         = ST_IDLE;
      end

      ST_FL_BEGIN: begin
        fl_ptr_next = '0;
        if (group_is_open) begin
          state_next = ST_FL_ISSUE;
        end else if (out_free) begin
          emit               = 1'b1;
          emit_kind          = KIND_BEGIN;
          group_is_open_next = 1'b1;
          state_next         = ST_FL_ISSUE;
        end
      end

      ST_FL_ISSUE: begin
        ram_re     = 1'b1;
        ram_raddr  = fl_ptr[PTR_W-1:0];
        state_next = ST_FL_EMIT;
      end

      // One delta per transfer; the next read is issued as each one leaves.
      ST_FL_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_DELTA;
          emit_delta = 1'b1;
          emit_last  = fl_last && !group_roll && (op_q == OP_RECORD);
          if (fl_last) begin
            pending_count_next = '0;
            group_count_next   = group_sum;
            state_next         = group_roll ? ST_FL_END : after_flush;
          end else begin
            fl_ptr_next = fl_ptr_plus1;
            ram_re      = 1'b1;
            ram_raddr   = fl_ptr_plus1[PTR_W-1:0];
          end
        end
      end

      ST_FL_END: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_END;
          state_next = ST_FL_REBEGIN;
        end
      end

      ST_FL_REBEGIN: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_kind        = KIND_BEGIN;
          emit_last        = (op_q == OP_RECORD);
          group_count_next = '0;
          state_next       = after_flush;
        end
      end

      ST_FIN_END: begin
        if (!group_is_open) begin
          state_next = ST_FIN_DONE;
        end else if (out_free) begin
          emit               = 1'b1;
          emit_kind          = KIND_END;
          group_is_open_next = 1'b0;
          state_next         = ST_FIN_DONE;
        end
      end

      ST_FIN_DONE: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = KIND_DONE;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (out_valid && out_stall);
    end
  end

  // Output register payload; non-delta results carry zero fields.
  always_ff @(posedge clk) begin
    if (emit) begin
      kind        <= emit_kind;
      last        <= emit_last;
      delta_index <= emit_delta ? DELTA_INDEX_W'(rd_idx) : '0;
      delta_old   <= emit_delta ? rd_old : '0;
      delta_new   <= emit_delta ? rd_new : '0;
    end
  end

  // The buffer never holds more entries than it has slots.
  `SDCB_ASSERT(a_count_bound, pending_count <= COUNT_W'(BUFFER_ENTRIES))
  // Between items the group count has already rolled over.
  `SDCB_ASSERT_IMPLY(a_group_bound, state == ST_IDLE, group_count < GROUP_W'(GROUP_LIMIT))
  // A search only runs over a non-empty buffer.
  `SDCB_ASSERT_IMPLY(a_search_nonempty, state == ST_SEARCH, pending_count != '0)
  // Flush reads stay inside the pending entries.
  `SDCB_ASSERT_IMPLY(a_flush_ptr, state == ST_FL_EMIT, fl_ptr < pending_count)
  // Done is the final result and follows a closed group.
  `SDCB_ASSERT_IMPLY(a_done_closed, out_valid && kind == KIND_DONE, !group_is_open && last)

endmodule
